### rtl/core/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// HART slave frame checker package
// Shared widths, register indexes, status codes and the command code.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // Payload and configuration widths.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned PosW      = 9;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned MfrW      = 6;

  // Header lengths, counted from the delimiter.
  localparam logic [PosW-1:0] ShortHdrLen = 9'd4;
  localparam logic [PosW-1:0] LongHdrLen  = 9'd8;

  // The address bits compared against the polling address or manufacturer.
  localparam logic [ByteW-1:0] AddrMask = 8'h3F;

  // Command that loads a new polling address.
  localparam logic [ByteW-1:0] CmdWritePollAddr = 8'd6;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] ShortDelimRst = 8'd2;
  localparam logic [ByteW-1:0] LongDelimRst  = 8'd130;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SLAVE_ENABLE  = 3'd0,
    REG_SHORT_DELIM   = 3'd1,
    REG_LONG_DELIM    = 3'd2,
    REG_MFR_CODE      = 3'd3,
    REG_DEV_TYPE      = 3'd4,
    REG_DEV_SERIAL    = 3'd5
  } cfg_reg_e;

  // Frame status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DELIM = 2'd1,
    ST_BCC_ERR   = 2'd2,
    ST_ADDR_ERR  = 2'd3
  } status_e;

endpackage

### rtl/core/hsfc_if.sv
// ----------------------------------------------------------------------------
// HART slave frame checker channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface hsfc_byte_if;
  logic                      valid;
  logic                      ready;
  logic [hsfc_pkg::ByteW-1:0] data_byte;
  logic                      frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Frame result channel.
interface hsfc_result_if;
  logic                        valid;
  logic                        ready;
  logic [hsfc_pkg::StatusW-1:0] status;
  logic [hsfc_pkg::ByteW-1:0]   command;
  logic                        long_frame;
  logic [hsfc_pkg::ByteW-1:0]   polling_address;

  modport source (output valid, output status, output command, output long_frame,
                  output polling_address, input ready);
  modport sink   (input valid, input status, input command, input long_frame,
                  input polling_address, output ready);
endinterface

### rtl/core/hart_slave_frame_checker_unit.sv
// Path: an accepted byte is held in the input register and checked there; a
// result it causes is registered in the result register that drives rsp_o.
// Throughput: one byte per cycle unless a waiting result stalls, set by the
// single input register feeding the checking logic and the result register.
// Reset: asynchronous active low; frame state cleared, polling address 0,
// slave mode on, delimiters 2 (short) and 130 (long), identity all zero.
// ----------------------------------------------------------------------------
// HART slave frame checker
// Checks received master request frames byte by byte: delimiter, address,
// byte count and BCC; reports status, command, frame kind, polling address.
// ----------------------------------------------------------------------------
module hart_slave_frame_checker_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [hsfc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [hsfc_pkg::CfgDataW-1:0]     cfg_data_i,
  // Byte and result channels.
  hsfc_byte_if.sink                         req_i,
  hsfc_result_if.source                     rsp_o
);

  // Configuration registers.
  logic                           slave_en_q;
  logic [hsfc_pkg::ByteW-1:0]     short_delim_q;
  logic [hsfc_pkg::ByteW-1:0]     long_delim_q;
  logic [hsfc_pkg::MfrW-1:0]      mfr_code_q;
  logic [hsfc_pkg::ByteW-1:0]     dev_type_q;
  logic [hsfc_pkg::CfgDataW-1:0]  dev_serial_q;

  // Input register.
  logic                           in_valid_q;
  logic [hsfc_pkg::ByteW-1:0]     in_byte_q;
  logic                           in_start_q;

  // Frame state.
  logic [hsfc_pkg::PosW-1:0]      pos_q, pos_d;
  logic                           active_q, active_d;
  logic                           is_long_q, is_long_d;
  logic [hsfc_pkg::ByteW-1:0]     bcc_q, bcc_d;
  logic [hsfc_pkg::ByteW-1:0]     len_q, len_d;
  logic                           addr_ok_q, addr_ok_d;
  logic [hsfc_pkg::ByteW-1:0]     cmd_q, cmd_d;
  logic [hsfc_pkg::ByteW-1:0]     first_q, first_d;
  logic [hsfc_pkg::ByteW-1:0]     poll_q, poll_d;

  // Result register.
  logic                           out_valid_q;
  hsfc_pkg::status_e              out_status_q;
  logic [hsfc_pkg::ByteW-1:0]     out_cmd_q;
  logic                           out_long_q;
  logic [hsfc_pkg::ByteW-1:0]     out_poll_q;

  // Result of the byte in the input register.
  logic                           res_valid;
  hsfc_pkg::status_e              res_status;
  logic [hsfc_pkg::ByteW-1:0]     res_cmd;
  logic                           res_long;

  logic                           advance;
  logic [hsfc_pkg::PosW-1:0]      hdr_len;
  logic                           at_bcc;
  logic [hsfc_pkg::ByteW-1:0]     masked_addr;

  // The checking stage moves on unless it would overwrite a waiting result.
  assign advance   = in_valid_q && (!out_valid_q || rsp_o.ready || !res_valid);
  assign req_i.ready = !in_valid_q || advance;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_en_q    <= 1'b1;
      short_delim_q <= hsfc_pkg::ShortDelimRst;
      long_delim_q  <= hsfc_pkg::LongDelimRst;
      mfr_code_q    <= '0;
      dev_type_q    <= '0;
      dev_serial_q  <= '0;
    end else if (cfg_we_i) begin
      case (hsfc_pkg::cfg_reg_e'(cfg_idx_i))
        hsfc_pkg::REG_SLAVE_ENABLE: slave_en_q    <= cfg_data_i[0];
        hsfc_pkg::REG_SHORT_DELIM:  short_delim_q <= cfg_data_i[hsfc_pkg::ByteW-1:0];
        hsfc_pkg::REG_LONG_DELIM:   long_delim_q  <= cfg_data_i[hsfc_pkg::ByteW-1:0];
        hsfc_pkg::REG_MFR_CODE:     mfr_code_q    <= cfg_data_i[hsfc_pkg::MfrW-1:0];
        hsfc_pkg::REG_DEV_TYPE:     dev_type_q    <= cfg_data_i[hsfc_pkg::ByteW-1:0];
        hsfc_pkg::REG_DEV_SERIAL:   dev_serial_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: a new byte enters whenever the stage is free or moving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_byte_q  <= req_i.data_byte;
      in_start_q <= req_i.frame_start;
    end
  end

  assign hdr_len     = is_long_q ? hsfc_pkg::LongHdrLen : hsfc_pkg::ShortHdrLen;
  assign at_bcc      = (pos_q >= hdr_len) && (pos_q == hdr_len + {1'b0, len_q});
  assign masked_addr = in_byte_q & hsfc_pkg::AddrMask;

  // Per-byte frame checking.
  always_comb begin
    pos_d      = pos_q;
    active_d   = active_q;
    is_long_d  = is_long_q;
    bcc_d      = bcc_q;
    len_d      = len_q;
    addr_ok_d  = addr_ok_q;
    cmd_d      = cmd_q;
    first_d    = first_q;
    poll_d     = poll_q;
    res_valid  = 1'b0;
    res_status = hsfc_pkg::ST_OK;
    res_cmd    = '0;
    res_long   = 1'b0;

    if (!slave_en_q) begin
      active_d = 1'b0;
    end else if (in_start_q) begin
      // Delimiter byte opens a new frame; an unknown delimiter is reported.
      pos_d     = 9'd1;
      bcc_d     = in_byte_q;
      len_d     = '0;
      addr_ok_d = 1'b1;
      cmd_d     = '0;
      first_d   = '0;
      if (in_byte_q == short_delim_q) begin
        is_long_d = 1'b0;
        active_d  = 1'b1;
      end else if (in_byte_q == long_delim_q) begin
        is_long_d = 1'b1;
        active_d  = 1'b1;
      end else begin
        is_long_d  = 1'b0;
        active_d   = 1'b0;
        res_valid  = 1'b1;
        res_status = hsfc_pkg::ST_BAD_DELIM;
      end
    end else if (active_q) begin
      if (at_bcc) begin
        // Checksum byte closes the frame; address error wins over BCC error.
        active_d  = 1'b0;
        res_valid = 1'b1;
        res_cmd   = cmd_q;
        res_long  = is_long_q;
        if (!addr_ok_q) begin
          res_status = hsfc_pkg::ST_ADDR_ERR;
        end else if (bcc_q != in_byte_q) begin
          res_status = hsfc_pkg::ST_BCC_ERR;
        end else begin
          res_status = hsfc_pkg::ST_OK;
        end
        if (res_status == hsfc_pkg::ST_OK && cmd_q == hsfc_pkg::CmdWritePollAddr &&
            len_q != '0) begin
          poll_d = first_q;
        end
      end else begin
        // Header and data bytes.
        if (!is_long_q) begin
          case (pos_q)
            9'd1: if (masked_addr != poll_q) addr_ok_d = 1'b0;
            9'd2: cmd_d   = in_byte_q;
            9'd3: len_d   = in_byte_q;
            9'd4: first_d = in_byte_q;
            default: ;
          endcase
        end else begin
          case (pos_q)
            9'd1: if (masked_addr[hsfc_pkg::MfrW-1:0] != mfr_code_q ||
                      masked_addr[hsfc_pkg::ByteW-1:hsfc_pkg::MfrW] != '0) begin
              addr_ok_d = 1'b0;
            end
            9'd2: if (in_byte_q != dev_type_q) addr_ok_d = 1'b0;
            9'd3: if (in_byte_q != dev_serial_q[23:16]) addr_ok_d = 1'b0;
            9'd4: if (in_byte_q != dev_serial_q[15:8]) addr_ok_d = 1'b0;
            9'd5: if (in_byte_q != dev_serial_q[7:0]) addr_ok_d = 1'b0;
            9'd6: cmd_d   = in_byte_q;
            9'd7: len_d   = in_byte_q;
            9'd8: first_d = in_byte_q;
            default: ;
          endcase
        end
        bcc_d = bcc_q ^ in_byte_q;
        pos_d = pos_q + 9'd1;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= 1'b0;
      is_long_q <= 1'b0;
      bcc_q     <= '0;
      len_q     <= '0;
      addr_ok_q <= 1'b1;
      cmd_q     <= '0;
      first_q   <= '0;
      poll_q    <= '0;
    end else if (advance) begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      is_long_q <= is_long_d;
      bcc_q     <= bcc_d;
      len_q     <= len_d;
      addr_ok_q <= addr_ok_d;
      cmd_q     <= cmd_d;
      first_q   <= first_d;
      poll_q    <= poll_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_status_q <= res_status;
      out_cmd_q    <= res_cmd;
      out_long_q   <= res_long;
      out_poll_q   <= poll_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.command         = out_cmd_q;
  assign rsp_o.long_frame      = out_long_q;
  assign rsp_o.polling_address = out_poll_q;

`ifndef ASSERT_OFF
  // A bad delimiter result carries no command and is never a long frame.
  a_bad_delim_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == hsfc_pkg::ST_BAD_DELIM) |->
      (out_cmd_q == '0 && !out_long_q))
    else $error("bad delimiter result with command or long flag");

  // With slave mode off no new result appears.
  a_silent_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!slave_en_q && !out_valid_q) |=> !out_valid_q)
    else $error("result produced while slave mode is off");

  // An open frame always has a nonzero byte position.
  a_active_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q != '0))
    else $error("open frame with byte position zero");

  // The polling address only changes with a good command 6 result.
  a_poll_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(poll_q) |->
      (out_valid_q && out_status_q == hsfc_pkg::ST_OK &&
       out_cmd_q == hsfc_pkg::CmdWritePollAddr && out_poll_q == poll_q))
    else $error("polling address changed without a good command 6");
`endif

endmodule
